// ===== hdl/drp_pkg.sv =====
// Shared types, constants and helpers for the descriptor ring producer.
// No dependencies; used by drp_avail_ram and descriptor_ring_producer.
package drp_pkg;

	localparam int RING_SIZE = 16;
	localparam int IDX_W     = $clog2(RING_SIZE);

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_GET  = 2'd0,
		OP_PUT  = 2'd1,
		OP_DROP = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NODATA   = 2'd1,
		ST_INVALID  = 2'd2,
		ST_LINKDOWN = 2'd3
	} status_t;

	// Write request into the available ring.
	typedef struct packed {
		logic en;
		idx_t addr;
		idx_t data;
	} ring_wr_t;

	// Next value of (counter modulo RING_SIZE) when the 32-bit counter steps by one.
	// The counter wrapping to zero brings the remainder back to zero.
	function automatic idx_t next_mod(input logic [31:0] cnt, input idx_t cur);
		idx_t res;
		if (cnt == 32'hFFFF_FFFF) begin
			res = '0;
		end else if (cur == IDX_W'(RING_SIZE - 1)) begin
			res = '0;
		end else begin
			res = cur + IDX_W'(1);
		end
		return res;
	endfunction

	// Index fields on the result side are four bits wide.
	function automatic logic [3:0] out4(input idx_t v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[3:0];
	endfunction

endpackage

// ===== hdl/drp_avail_ram.sv =====
// Available ring storage: synchronous RAM with a registered read port.
// Per-entry valid bits make an unwritten entry read as its own address.
// Depends on drp_pkg.
module drp_avail_ram (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  drp_pkg::idx_t    rd_addr,
	output drp_pkg::idx_t    rd_data,
	input  drp_pkg::ring_wr_t wr,
	input  logic             clear
);

	drp_pkg::idx_t                      mem [drp_pkg::RING_SIZE];
	logic [drp_pkg::RING_SIZE-1:0]      valid_q;
	drp_pkg::idx_t                      rd_word_q;
	drp_pkg::idx_t                      rd_addr_q;
	logic                               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry that was never written since the last refill holds its own index.
	assign rd_data = rd_valid_q ? rd_word_q : rd_addr_q;

endmodule

// ===== hdl/descriptor_ring_producer.sv =====
// Descriptor ring producer top: sequencing, pointers, result; uses drp_pkg, drp_avail_ram.
// Sequencing: request fields are registered on acceptance, and the result is registered
// when the S_EXEC step fires; a new request is taken only in S_IDLE, after the ring RAM
// read and the read-modify-write step; a full result register not yet taken holds S_EXEC.
// Reset: pointers, heartbeat and flags clear asynchronously; the ring valid bits
// clear at once, so the ring reads as 0..N-1 with no clearing pass.
module descriptor_ring_producer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,    // message_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,   // desc_index[15:0], used_length[47:16],
	                                    // reader_ready[48], reader_heart[80:49]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // got_index[3:0], got_length[35:4],
	                                    // used_write[36], used_slot[40:37],
	                                    // used_id[44:41], used_len[76:45],
	                                    // reader_dead[77]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t            state_q;
	logic [31:0]       msg_size_q;
	logic [31:0]       head_q, tail_q, used_tail_q, last_heart_q;
	drp_pkg::idx_t     head_mod_q, tail_mod_q, used_mod_q;
	logic              refill_q;

	drp_pkg::opcode_t  op_s1;
	logic [15:0]       idx_s1;
	logic [31:0]       len_s1;
	logic              ready_s1;
	logic [31:0]       heart_s1;

	logic              out_valid_q;
	drp_pkg::status_t  out_status_q;
	logic [79:0]       out_data_q;

	logic              accept, rd_en, exec_fire, ring_clear;
	drp_pkg::idx_t     rd_addr, rd_data;
	drp_pkg::ring_wr_t ring_wr;

	drp_pkg::status_t  r_status;
	logic [3:0]        r_got_index, r_used_slot, r_used_id;
	logic [31:0]       r_got_length, r_used_len;
	logic              r_used_write, r_dead;
	logic [31:0]       head_n, tail_n, used_tail_n, last_heart_n;
	drp_pkg::idx_t     head_mod_n, tail_mod_n, used_mod_n;
	logic              refill_n;
	logic [31:0]       eff_head, eff_tail;
	drp_pkg::idx_t     eff_head_mod, eff_tail_mod, got_idx;
	logic              idx_bad;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign exec_fire     = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

	// A pending refill makes the get read slot zero.
	assign rd_en   = accept && (drp_pkg::opcode_t'(s_axis_tuser) == drp_pkg::OP_GET);
	assign rd_addr = refill_q ? '0 : head_mod_q;

	drp_avail_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (ring_wr),
		.clear   (ring_clear)
	);

	always_comb begin
		r_status     = drp_pkg::ST_OK;
		r_got_index  = '0;
		r_got_length = '0;
		r_used_write = 1'b0;
		r_used_slot  = '0;
		r_used_id    = '0;
		r_used_len   = '0;
		r_dead       = 1'b0;
		head_n       = head_q;
		head_mod_n   = head_mod_q;
		tail_n       = tail_q;
		tail_mod_n   = tail_mod_q;
		used_tail_n  = used_tail_q;
		used_mod_n   = used_mod_q;
		last_heart_n = last_heart_q;
		refill_n     = refill_q;
		ring_wr      = '0;
		ring_clear   = 1'b0;
		idx_bad      = (idx_s1 >= 16'(drp_pkg::RING_SIZE));
		eff_head     = refill_q ? 32'd0 : head_q;
		eff_tail     = refill_q ? 32'(drp_pkg::RING_SIZE) : tail_q;
		eff_head_mod = refill_q ? '0 : head_mod_q;
		eff_tail_mod = refill_q ? '0 : tail_mod_q;
		got_idx      = refill_q ? '0 : rd_data;
		case (op_s1)
			drp_pkg::OP_GET: begin
				ring_clear = refill_q;
				refill_n   = 1'b0;
				tail_n     = eff_tail;
				tail_mod_n = eff_tail_mod;
				head_n     = eff_head;
				head_mod_n = eff_head_mod;
				if (eff_head == eff_tail) begin
					r_status = drp_pkg::ST_NODATA;
				end else begin
					r_got_index  = drp_pkg::out4(got_idx);
					r_got_length = msg_size_q;
					head_n       = eff_head + 32'd1;
					head_mod_n   = drp_pkg::next_mod(eff_head, eff_head_mod);
				end
			end
			drp_pkg::OP_PUT, drp_pkg::OP_DROP: begin
				if (idx_bad) begin
					r_status = drp_pkg::ST_INVALID;
				end else if ((op_s1 == drp_pkg::OP_PUT) && ready_s1) begin
					r_used_write = 1'b1;
					r_used_slot  = drp_pkg::out4(used_mod_q);
					r_used_id    = drp_pkg::out4(idx_s1[drp_pkg::IDX_W-1:0]);
					r_used_len   = len_s1;
					used_tail_n  = used_tail_q + 32'd1;
					used_mod_n   = drp_pkg::next_mod(used_tail_q, used_mod_q);
				end else begin
					// Give the index back to the available ring.
					ring_wr.en   = 1'b1;
					ring_wr.addr = tail_mod_q;
					ring_wr.data = idx_s1[drp_pkg::IDX_W-1:0];
					tail_n       = tail_q + 32'd1;
					tail_mod_n   = drp_pkg::next_mod(tail_q, tail_mod_q);
					r_status     = (op_s1 == drp_pkg::OP_PUT) ? drp_pkg::ST_LINKDOWN
					                                          : drp_pkg::ST_OK;
				end
			end
			drp_pkg::OP_TICK: begin
				if (ready_s1) begin
					if (heart_s1 == last_heart_q) begin
						refill_n = 1'b1;
						r_dead   = 1'b1;
					end else begin
						last_heart_n = heart_s1;
					end
				end
			end
			default: begin
				r_status = drp_pkg::ST_OK;
			end
		endcase
		if (!exec_fire) begin
			ring_wr    = '0;
			ring_clear = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= drp_pkg::opcode_t'(s_axis_tuser);
			idx_s1   <= s_axis_tdata[15:0];
			len_s1   <= s_axis_tdata[47:16];
			ready_s1 <= s_axis_tdata[48];
			heart_s1 <= s_axis_tdata[80:49];
		end
		if (exec_fire) begin
			out_data_q <= {2'b00, r_dead, r_used_len, r_used_id, r_used_slot,
			               r_used_write, r_got_length, r_got_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			msg_size_q   <= '0;
			head_q       <= '0;
			head_mod_q   <= '0;
			tail_q       <= 32'(drp_pkg::RING_SIZE);
			tail_mod_q   <= '0;
			used_tail_q  <= '0;
			used_mod_q   <= '0;
			last_heart_q <= '0;
			refill_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= drp_pkg::ST_OK;
		end else begin
			if (cfg_wr_en) begin
				msg_size_q <= cfg_wr_data;
			end
			// A new result replaces the one taken in the same cycle.
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q      <= S_IDLE;
						head_q       <= head_n;
						head_mod_q   <= head_mod_n;
						tail_q       <= tail_n;
						tail_mod_q   <= tail_mod_n;
						used_tail_q  <= used_tail_n;
						used_mod_q   <= used_mod_n;
						last_heart_q <= last_heart_n;
						refill_q     <= refill_n;
						out_status_q <= r_status;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_refill_done: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && (op_s1 == drp_pkg::OP_GET) |=> !refill_q)
		else $error("refill flag survived a get");

	a_mod_track: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) |-> (head_mod_q == tail_mod_q))
		else $error("ring slot pointers disagree with equal counters");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid_q && (state_q == S_IDLE))
		else $error("completed request produced no result");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_mod_q < drp_pkg::IDX_W'(drp_pkg::RING_SIZE - 1)) ||
		(head_mod_q == drp_pkg::IDX_W'(drp_pkg::RING_SIZE - 1)))
		else $error("head slot beyond ring");
`endif

endmodule
